// ===== src/idle_connection_cache_top_macros.svh =====
// assertion macros for the idle connection cache
// used by idle_connection_cache_top, no other dependencies
`ifndef IDLE_CONNECTION_CACHE_TOP_MACROS_SVH
`define IDLE_CONNECTION_CACHE_TOP_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define ICC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("icc assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define ICC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("icc assertion failed");

`endif

// ===== src/icc_pkg.sv =====
// types and constants shared by the idle connection cache
// no dependencies
package icc_pkg;

    // request codes
    typedef enum logic [1:0] {
        FUNC_STORE = 2'd0,
        FUNC_TAKE  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_REAP  = 2'd3
    } t_func;

    localparam int HOST_W    = 32;
    localparam int CONN_W    = 16;
    localparam int TIME_W    = 48;
    localparam int TMO_W     = 20;
    localparam int ECNT_W    = 4;
    // running count width, enough for up to 127 slots
    localparam int CNT_W     = 7;
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 20'd6000;

    // request word travelling down the cell row
    typedef struct packed {
        t_func              func;
        logic [HOST_W-1:0]  host;
        logic [CONN_W-1:0]  conn;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  expiry;
        logic               done;
        logic [CONN_W-1:0]  conn_out;
        logic [CNT_W-1:0]   cnt;
    } t_token;

endpackage

// ===== src/icc_req_if.sv =====
// request channel of the idle connection cache
// depends on nothing
interface icc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] host_key;
    logic [15:0] conn_handle;
    logic [47:0] now_time;

    modport source (output valid, func, host_key, conn_handle, now_time, input ready);
    modport sink   (input valid, func, host_key, conn_handle, now_time, output ready);
endinterface

// ===== src/icc_rsp_if.sv =====
// result channel of the idle connection cache
// depends on nothing
interface icc_rsp_if;
    logic        valid;
    logic        ready;
    logic        store_ok;
    logic        hit;
    logic [15:0] conn_out;
    logic [3:0]  entry_count;

    modport source (output valid, store_ok, hit, conn_out, entry_count, input ready);
    modport sink   (input valid, store_ok, hit, conn_out, entry_count, output ready);
endinterface

// ===== src/icc_cell.sv =====
// one slot of the idle connection table plus its stage of the request row
// depends on icc_pkg
module icc_cell
    import icc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_token i_tok,
    output logic   o_vld,
    output t_token o_tok
);

    logic              r_valid;
    logic [HOST_W-1:0] r_host;
    logic [CONN_W-1:0] r_conn;
    logic [TIME_W-1:0] r_expiry;
    logic              r_tok_vld;
    t_token            r_tok;

    logic   n_valid;
    t_token n_tok;
    logic   w_write;

    // apply the request to this slot
    always_comb begin
        n_valid = r_valid;
        n_tok   = i_tok;
        w_write = 1'b0;
        unique case (i_tok.func)
            FUNC_STORE: begin
                if (!i_tok.done && !r_valid) begin
                    n_valid   = 1'b1;
                    w_write   = 1'b1;
                    n_tok.done = 1'b1;
                end
            end
            FUNC_TAKE: begin
                if (!i_tok.done && r_valid && (r_host == i_tok.host)) begin
                    n_valid        = 1'b0;
                    n_tok.done     = 1'b1;
                    n_tok.conn_out = r_conn;
                end
            end
            FUNC_CLEAR: begin
                n_valid = 1'b0;
            end
            FUNC_REAP: begin
                if (r_valid && (i_tok.now > r_expiry)) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
                n_valid = r_valid;
            end
        endcase
        n_tok.cnt = i_tok.cnt + CNT_W'(n_valid);
    end

    // slot state and stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok_vld <= 1'b0;
        end else if (i_en) begin
            r_tok_vld <= i_vld;
            if (i_vld) begin
                r_valid <= n_valid;
                r_tok   <= n_tok;
                if (w_write) begin
                    r_host   <= i_tok.host;
                    r_conn   <= i_tok.conn;
                    r_expiry <= i_tok.expiry;
                end
            end
        end
    end

    assign o_vld = r_tok_vld;
    assign o_tok = r_tok;

endmodule

// ===== src/idle_connection_cache_top.sv =====
// idle connection cache: a request word walks a row of NUM_SLOTS cells, one per cycle while
// a finished word at the end of the row is not held by a full, unread output register.
// A request passes the entry stage, the walk through the cell row and the capture into the
// output register; the next request is taken only once that capture has happened.
// a finished result waits in the output register while the next request is taken.
// reset (synchronous, active low) empties every slot and sets idle_timeout to 6000.
// depends on icc_pkg, icc_req_if, icc_rsp_if, icc_cell and the macro header
`include "idle_connection_cache_top_macros.svh"

module idle_connection_cache_top
    import icc_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    icc_req_if.sink          i_req,
    icc_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [TMO_W-1:0] i_cfg_wdata
);

    logic [TMO_W-1:0] r_timeout;
    logic             r_busy;
    logic             r_tok0_vld;
    t_token           r_tok0;
    logic             r_out_vld;
    logic             r_store_ok;
    logic             r_hit;
    logic [CONN_W-1:0] r_conn_out;
    logic [ECNT_W-1:0] r_ecnt;

    logic               w_acc;
    logic               w_en;
    logic               w_done;
    logic [TIME_W:0]    w_sum;
    logic [TIME_W-1:0]  w_exp;
    logic [NUM_SLOTS:0] w_vld;
    t_token             w_tok [NUM_SLOTS+1];
    t_token             w_last;
    logic [CNT_W+ECNT_W-1:0] w_cnt_ext;

    // handshake and row advance
    assign w_acc       = i_req.valid && i_req.ready;
    assign i_req.ready = !r_busy;
    assign w_done      = w_vld[NUM_SLOTS];
    assign w_en        = !(w_done && r_out_vld && !o_rsp.ready);

    // expiry of a stored entry, saturating at the top of the time range
    assign w_sum = {1'b0, i_req.now_time} + {{(TIME_W + 1 - TMO_W){1'b0}}, r_timeout};
    assign w_exp = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // entry stage and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_tok0_vld <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy     <= 1'b1;
                r_tok0_vld <= 1'b1;
            end else begin
                if (w_en) begin
                    r_tok0_vld <= 1'b0;
                end
                if (w_done && w_en) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (w_acc) begin
            r_tok0.func     <= t_func'(i_req.func);
            r_tok0.host     <= i_req.host_key;
            r_tok0.conn     <= i_req.conn_handle;
            r_tok0.now      <= i_req.now_time;
            r_tok0.expiry   <= w_exp;
            r_tok0.done     <= 1'b0;
            r_tok0.conn_out <= '0;
            r_tok0.cnt      <= '0;
        end
    end

    assign w_vld[0] = r_tok0_vld;
    assign w_tok[0] = r_tok0;

    // row of slot cells, slot 0 first
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        icc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_tok   (w_tok[g]),
            .o_vld   (w_vld[g+1]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last    = w_tok[NUM_SLOTS];
    assign w_cnt_ext = {{ECNT_W{1'b0}}, w_last.cnt};

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_done && w_en) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
        if (w_done && w_en) begin
            r_store_ok <= (w_last.func == FUNC_STORE) && w_last.done;
            r_hit      <= (w_last.func == FUNC_TAKE) && w_last.done;
            r_conn_out <= w_last.conn_out;
            r_ecnt     <= w_cnt_ext[ECNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.store_ok    = r_store_ok;
    assign o_rsp.hit         = r_hit;
    assign o_rsp.conn_out    = r_conn_out;
    assign o_rsp.entry_count = r_ecnt;

    // checks on the request row
    `ICC_ASSERT_NOW(a_idle_row_empty, !r_busy, w_vld == '0)
    `ICC_ASSERT_NOW(a_one_word_in_row, 1'b1, $countones(w_vld) <= 1)
    `ICC_ASSERT_NEXT(a_accept_busy, w_acc, r_busy && r_tok0_vld)

endmodule

// ===== tb/sv/tb_idle_connection_cache_top.sv =====
// self-checking testbench for idle_connection_cache_top: directed table, then random phases
// depends on icc_pkg, icc_req_if, icc_rsp_if and the cache rtl
module tb_idle_connection_cache_top;
    import icc_pkg::*;

    localparam int SLOTS = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 325;
    localparam int HOLD_CYCLES = 300;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // one result word as the block returns it
    typedef struct packed {
        logic              store_ok;
        logic              hit;
        logic [CONN_W-1:0] conn_out;
        logic [ECNT_W-1:0] entry_count;
    } t_reply;

    // one row of the directed table
    typedef struct {
        t_func             func;
        logic [HOST_W-1:0] host;
        logic [CONN_W-1:0] conn;
        logic [TIME_W-1:0] now;
        bit                typed;
        t_reply            want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TMO_W-1:0] i_cfg_wdata;

    icc_req_if req_ch ();
    icc_rsp_if rsp_ch ();

    idle_connection_cache_top #(
        .NUM_SLOTS(SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // shadow copy of the table and the timeout
    bit                slot_used [SLOTS];
    logic [HOST_W-1:0] slot_host [SLOTS];
    logic [CONN_W-1:0] slot_conn [SLOTS];
    logic [TIME_W-1:0] slot_exp  [SLOTS];
    int                live_cnt;
    logic [TMO_W-1:0]  cur_timeout;

    t_reply reply_q[$];
    t_row   script[$];
    int     errors = 0;
    int     cycle_cnt = 0;
    bit     rx_hold_req = 0;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // expected result of one request, updates the shadow table
    function automatic t_reply cache_access(t_func f, logic [HOST_W-1:0] h,
                                            logic [CONN_W-1:0] c, logic [TIME_W-1:0] n);
        t_reply r;
        logic [TIME_W:0] sum;
        bit done;
        r = '0;
        done = 0;
        case (f)
            FUNC_STORE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && !slot_used[i]) begin
                        sum = {1'b0, n} + {{(TIME_W+1-TMO_W){1'b0}}, cur_timeout};
                        slot_used[i] = 1;
                        slot_host[i] = h;
                        slot_conn[i] = c;
                        slot_exp[i]  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                        live_cnt++;
                        r.store_ok = 1'b1;
                        done = 1;
                    end
                end
            end
            FUNC_TAKE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!done && slot_used[i] && slot_host[i] == h) begin
                        r.hit = 1'b1;
                        r.conn_out = slot_conn[i];
                        slot_used[i] = 0;
                        live_cnt--;
                        done = 1;
                    end
                end
            end
            FUNC_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) slot_used[i] = 0;
                live_cnt = 0;
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[i] && n > slot_exp[i]) begin
                        slot_used[i] = 0;
                        live_cnt--;
                    end
                end
            end
        endcase
        r.entry_count = ECNT_W'(live_cnt);
        return r;
    endfunction

    function automatic t_row mk_row(t_func f, logic [HOST_W-1:0] h, logic [CONN_W-1:0] c,
                                    logic [TIME_W-1:0] n, bit typed, logic ok, logic hit,
                                    logic [CONN_W-1:0] co, logic [ECNT_W-1:0] cnt);
        t_row r;
        r.func = f;
        r.host = h;
        r.conn = c;
        r.now = n;
        r.typed = typed;
        r.want = '{store_ok: ok, hit: hit, conn_out: co, entry_count: cnt};
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one request word and wait until it is taken
    task automatic send_req(t_func f, logic [HOST_W-1:0] h, logic [CONN_W-1:0] c,
                            logic [TIME_W-1:0] n, int gap);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.host_key    <= h;
        req_ch.conn_handle <= c;
        req_ch.now_time    <= n;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [TMO_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_timeout = v;
    endtask

    task automatic note_fail(string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_reply exp_w;
        t_reply got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = '{store_ok: rsp_ch.store_ok, hit: rsp_ch.hit,
                    conn_out: rsp_ch.conn_out, entry_count: rsp_ch.entry_count};
            if (reply_q.size() == 0) begin
                note_fail($sformatf("unexpected result word ok=%0b hit=%0b conn=%h cnt=%0d",
                                    got.store_ok, got.hit, got.conn_out, got.entry_count));
            end else begin
                exp_w = reply_q.pop_front();
                if (got.store_ok !== exp_w.store_ok || got.hit !== exp_w.hit ||
                    got.conn_out !== exp_w.conn_out || got.entry_count !== exp_w.entry_count)
                    note_fail($sformatf(
                        "mismatch: exp ok=%0b hit=%0b conn=%h cnt=%0d, got ok=%0b hit=%0b conn=%h cnt=%0d",
                        exp_w.store_ok, exp_w.hit, exp_w.conn_out, exp_w.entry_count,
                        got.store_ok, got.hit, got.conn_out, got.entry_count));
            end
        end
    end

    // receiver: random stalls, bursts of steady ready, one long hold-off on request
    initial begin
        int run;
        int gap;
        rsp_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // stimulus
    initial begin
        t_reply pred;
        t_row row;
        t_func f;
        logic [HOST_W-1:0] host_pool [6];
        logic [HOST_W-1:0] h;
        logic [TIME_W-1:0] now_t;
        logic [TMO_W-1:0]  tmo_list [6];
        int r;
        bit no_gaps;

        req_ch.valid       <= 1'b0;
        req_ch.func        <= FUNC_STORE;
        req_ch.host_key    <= '0;
        req_ch.conn_handle <= '0;
        req_ch.now_time    <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        i_rst_n            <= 1'b0;

        foreach (slot_used[i]) slot_used[i] = 0;
        live_cnt = 0;
        cur_timeout = TIMEOUT_RST;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, reset timeout of 6000
        script.push_back(mk_row(FUNC_TAKE,  32'h0, 16'h0, 48'd0, 1, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_REAP,  32'h0, 16'h0, 48'd0, 1, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_STORE, 32'h0, 16'h0, 48'd0, 1, 1, 0, 16'h0, 4'd1));
        script.push_back(mk_row(FUNC_STORE, 32'hFFFFFFFF, 16'hFFFF, 48'd100, 1, 1, 0, 16'h0, 4'd2));
        // expiry saturates at the top of the time range
        script.push_back(mk_row(FUNC_STORE, 32'h12345678, 16'h1234, TIME_MAX, 1, 1, 0, 16'h0, 4'd3));
        script.push_back(mk_row(FUNC_STORE, 32'h0, 16'h00AA, 48'd200, 1, 1, 0, 16'h0, 4'd4));
        script.push_back(mk_row(FUNC_STORE, 32'h9ABCDEF0, 16'h5555, 48'd1000, 1, 1, 0, 16'h0, 4'd5));
        script.push_back(mk_row(FUNC_STORE, 32'h0F0F0F0F, 16'hAAAA, 48'd1000, 1, 1, 0, 16'h0, 4'd6));
        script.push_back(mk_row(FUNC_STORE, 32'hF0F0F0F0, 16'h8001, 48'd1000, 1, 1, 0, 16'h0, 4'd7));
        script.push_back(mk_row(FUNC_STORE, 32'h00000001, 16'h7FFE, 48'd1000, 1, 1, 0, 16'h0, 4'd8));
        // table full, store refused
        script.push_back(mk_row(FUNC_STORE, 32'h00000002, 16'h0001, 48'd1000, 1, 0, 0, 16'h0, 4'd8));
        // duplicate host: lowest slot first, then the next, then a miss
        script.push_back(mk_row(FUNC_TAKE,  32'h0, 16'hFFFF, 48'd1000, 1, 0, 1, 16'h0000, 4'd7));
        script.push_back(mk_row(FUNC_TAKE,  32'h0, 16'h0, 48'd1000, 1, 0, 1, 16'h00AA, 4'd6));
        script.push_back(mk_row(FUNC_TAKE,  32'h0, 16'h0, 48'd1000, 1, 0, 0, 16'h0, 4'd6));
        // expiry equal to now is kept, one past it is reaped
        script.push_back(mk_row(FUNC_REAP,  32'h0, 16'h0, 48'd6100, 0, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_REAP,  32'h0, 16'h0, 48'd6101, 0, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_TAKE,  32'hFFFFFFFF, 16'h0, 48'd6101, 0, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_STORE, 32'h00000002, 16'h0001, 48'd6101, 0, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_REAP,  32'h0, 16'h0, TIME_MAX, 0, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_TAKE,  32'h12345678, 16'h0, TIME_MAX, 0, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_STORE, 32'h0, 16'hFFFF, 48'd5, 0, 0, 0, 16'h0, 4'd0));
        // clear ignores its other fields
        script.push_back(mk_row(FUNC_CLEAR, 32'hFFFFFFFF, 16'hFFFF, TIME_MAX, 1, 0, 0, 16'h0, 4'd0));
        script.push_back(mk_row(FUNC_TAKE,  32'h0, 16'h0, 48'd5, 1, 0, 0, 16'h0, 4'd0));

        foreach (script[k]) begin
            row = script[k];
            send_req(row.func, row.host, row.conn, row.now, pick_gap());
            pred = cache_access(row.func, row.host, row.conn, row.now);
            reply_q.push_back(row.typed ? row.want : pred);
        end
        drain();

        // random phases, each under its own timeout
        tmo_list[0] = 20'd0;
        tmo_list[1] = 20'hFFFFF;
        tmo_list[2] = 20'd1;
        tmo_list[3] = TMO_W'($urandom);
        tmo_list[4] = 20'd16;
        tmo_list[5] = TMO_W'($urandom_range(0, 4000));
        now_t = '0;
        no_gaps = 0;
        for (int p = 0; p < 6; p++) begin
            write_timeout(tmo_list[p]);
            foreach (host_pool[j]) host_pool[j] = $urandom;
            if (p == 1) rx_hold_req = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 40) f = FUNC_STORE;
                else if (r < 75) f = FUNC_TAKE;
                else if (r < 95) f = FUNC_REAP;
                else f = FUNC_CLEAR;
                h = ($urandom_range(0, 4) == 0) ? HOST_W'($urandom)
                                                : host_pool[$urandom_range(0, 5)];
                // time mostly creeps forward, sometimes jumps or sits near the top
                r = $urandom_range(0, 99);
                if (r < 70) now_t = now_t + $urandom_range(0, (cur_timeout >> 2) + 2);
                else if (r < 94) now_t = now_t + $urandom_range(0, cur_timeout * 2 + 2);
                else if (r < 97) now_t = TIME_MAX - $urandom_range(0, cur_timeout);
                else now_t = TIME_W'({$urandom, $urandom});
                send_req(f, h, CONN_W'($urandom), now_t, no_gaps ? 0 : pick_gap());
                reply_q.push_back(cache_access(f, h, req_ch.conn_handle, now_t));
            end
            drain();
        end

        repeat (4 * SLOTS) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
